// ----- sv/sgd_pkg.sv -----
package sgd_pkg;

  // line store depth and field widths
  localparam int unsigned MAX_WIDTH = 2048;
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W     = 12;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned IDX_W     = 2;
  localparam int unsigned GRAD_W    = 12;
  localparam int unsigned ABS_W     = 10;
  localparam int unsigned SQ_W      = 21;
  localparam int unsigned ROOT_W    = 11;
  localparam int unsigned DIR_W     = 2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;

  // reset values of the registers
  localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;

  // item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // angle bins
  localparam logic [DIR_W-1:0] DIR_0   = 2'd0;
  localparam logic [DIR_W-1:0] DIR_45  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_90  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_135 = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_CALC = 5'b00100,
    S_SQ   = 5'b01000,
    S_ROOT = 5'b10000
  } state_e;

  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] value;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

endpackage

// ----- sv/sobel_gradient_direction.sv -----
// Sobel gradient magnitude and direction over a raster stream of grey pixels.
// Input channel: in_valid_i / in_stall_o carry one item, a pixel (kind 0) or a
// drain tick (kind 1). Output channel: out_valid_o / out_stall_i carry one
// result with its row, column, rounded magnitude, angle bin and a frame-last
// flag. A result belongs to the pixel that entered frame_width+1 pixels
// earlier; drain ticks flush the border results still pending at the end.
// An item that yields no result passes through accept, line store read and
// window update; one that yields a result then also squares and waits on the
// magnitude from an iterative square root that resolves one bit per cycle.
// Only one item is in work at a time; in_stall_o is low only while idle.
// The output register holds a finished result while out_stall_i is high, and
// the next item is accepted meanwhile; its result waits until the slot frees.
// Reset clears the window, the row and column counters and the pending count
// and sets frame_width to 640 and frame_height to 480. The line stores are not
// cleared; unwritten entries only feed border results, which are zero.
// A configuration write to either register restarts the frame at row 0,
// column 0 and drops the pending results.
module sobel_gradient_direction (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sgd_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [sgd_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         in_kind_i,
  input  logic [sgd_pkg::PIX_W-1:0]    in_pixel_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sgd_pkg::ROW_W-1:0]    out_row_o,
  output logic [sgd_pkg::COL_W-1:0]    out_col_o,
  output logic [sgd_pkg::ROOT_W-1:0]   magnitude_o,
  output logic [sgd_pkg::DIR_W-1:0]    direction_o,
  output logic                         frame_last_o
);

  localparam int unsigned PW = sgd_pkg::PIX_W;
  localparam int unsigned GW = sgd_pkg::GRAD_W;
  localparam int unsigned AW = sgd_pkg::ABS_W;
  localparam int unsigned CW = sgd_pkg::CFG_W;

  sgd_pkg::state_e state_q, state_d;

  logic [CW-1:0]               width_q, height_q;
  logic [CW-1:0]               w_eff, h_eff;
  logic [sgd_pkg::ROW_W-1:0]   in_row_q, emit_row_q;
  logic [sgd_pkg::COL_W-1:0]   in_col_q, emit_col_q;
  logic [CW-1:0]               pending_q;
  logic [PW-1:0]               win_q [6];
  logic                        kind_q;
  logic [PW-1:0]               pix_q;
  logic [PW-1:0]               up_rd, mid_rd;
  logic                        restart;
  logic                        line_we;

  // gradient datapath
  logic signed [GW-1:0]        gx, gy;
  logic signed [GW-1:0]        gx_q, gy_q;
  logic [AW-1:0]               ax, ay;
  logic [AW:0]                 sum_xy;
  logic [AW-1:0]               dif_xy;
  logic [2*AW-1:0]             ax2_q;
  logic [2*AW+1:0]             psum_q;
  logic [2*AW-1:0]             pdif_q;
  logic                        zero_q, ygt_q, same_q;
  logic                        interior, emit, last;
  logic                        emit_last_q;
  logic [sgd_pkg::ROW_W-1:0]   res_row_q;
  logic [sgd_pkg::COL_W-1:0]   res_col_q;
  logic [sgd_pkg::DIR_W-1:0]   dir;
  logic                        load_out;

  sgd_pkg::sqrt_req_t sq_req;
  sgd_pkg::sqrt_rsp_t sq_rsp;

  // effective frame size
  always_comb begin
    w_eff = width_q;
    if (width_q == '0) w_eff = CW'(1);
    if (width_q > CW'(sgd_pkg::MAX_WIDTH)) w_eff = CW'(sgd_pkg::MAX_WIDTH);
    h_eff = (height_q == '0) ? CW'(1) : height_q;
  end

  assign restart = cfg_we_i &&
                   (cfg_idx_i == sgd_pkg::REG_WIDTH || cfg_idx_i == sgd_pkg::REG_HEIGHT);

  // line stores
  assign line_we = (state_q == sgd_pkg::S_CALC) && (kind_q == sgd_pkg::KIND_PIXEL);

  sgd_ram #(.WIDTH(PW), .DEPTH(sgd_pkg::MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (in_col_q),
    .wdata_i (mid_rd),
    .raddr_i (in_col_q),
    .rdata_o (up_rd)
  );

  sgd_ram #(.WIDTH(PW), .DEPTH(sgd_pkg::MAX_WIDTH)) u_middle (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (in_col_q),
    .wdata_i (pix_q),
    .raddr_i (in_col_q),
    .rdata_o (mid_rd)
  );

  // window gradients
  always_comb begin
    gx = (GW'(win_q[0]) + (GW'(win_q[3]) <<< 1) + GW'(up_rd))
       - (GW'(win_q[2]) + (GW'(win_q[5]) <<< 1) + GW'(pix_q));
    gy = (GW'(win_q[0]) + (GW'(win_q[1]) <<< 1) + GW'(win_q[2]))
       - (GW'(up_rd) + (GW'(mid_rd) <<< 1) + GW'(pix_q));
  end

  // region and result decision
  always_comb begin
    interior = (emit_row_q >= sgd_pkg::ROW_W'(3)) &&
               ({1'b0, emit_row_q} + 13'd3 <= {1'b0, h_eff}) &&
               (emit_col_q >= sgd_pkg::COL_W'(3)) &&
               ({2'b0, emit_col_q} + 13'd3 <= {1'b0, w_eff});
    last     = (emit_row_q == h_eff - 1'b1) && ({1'b0, emit_col_q} == w_eff - 1'b1);
    if (kind_q == sgd_pkg::KIND_PIXEL) begin
      emit = (pending_q == w_eff + 1'b1);
    end else begin
      emit = (pending_q != '0) && !interior;
    end
  end

  // magnitudes of the registered gradients
  assign ax     = AW'(gx_q < 0 ? -gx_q : gx_q);
  assign ay     = AW'(gy_q < 0 ? -gy_q : gy_q);
  assign sum_xy = {1'b0, ax} + {1'b0, ay};
  assign dif_xy = ay - ax;

  assign sq_req.start = (state_q == sgd_pkg::S_SQ);
  assign sq_req.value = sgd_pkg::SQ_W'(ax * ax) + sgd_pkg::SQ_W'(ay * ay);

  sgd_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sq_req),
    .rsp_o  (sq_rsp)
  );

  // angle bin from the registered products
  always_comb begin
    if (zero_q) begin
      dir = sgd_pkg::DIR_0;
    end else if (psum_q < {1'b0, ax2_q, 1'b0}) begin
      dir = sgd_pkg::DIR_0;
    end else if (ygt_q && ({1'b0, pdif_q} > {ax2_q, 1'b0})) begin
      dir = sgd_pkg::DIR_90;
    end else if (same_q) begin
      dir = sgd_pkg::DIR_45;
    end else begin
      dir = sgd_pkg::DIR_135;
    end
  end

  assign load_out = (state_q == sgd_pkg::S_ROOT) && sq_rsp.done &&
                    (!out_valid_o || !out_stall_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      sgd_pkg::S_IDLE: if (in_valid_i) state_d = sgd_pkg::S_READ;
      sgd_pkg::S_READ: state_d = sgd_pkg::S_CALC;
      sgd_pkg::S_CALC: state_d = emit ? sgd_pkg::S_SQ : sgd_pkg::S_IDLE;
      sgd_pkg::S_SQ:   state_d = sgd_pkg::S_ROOT;
      sgd_pkg::S_ROOT: if (load_out) state_d = sgd_pkg::S_IDLE;
      default:         state_d = sgd_pkg::S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != sgd_pkg::S_IDLE);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sgd_pkg::S_IDLE;
      width_q    <= sgd_pkg::WIDTH_RST;
      height_q   <= sgd_pkg::HEIGHT_RST;
      in_row_q   <= '0;
      in_col_q   <= '0;
      emit_row_q <= '0;
      emit_col_q <= '0;
      pending_q  <= '0;
      out_valid_o <= 1'b0;
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && cfg_idx_i == sgd_pkg::REG_WIDTH)  width_q  <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == sgd_pkg::REG_HEIGHT) height_q <= cfg_data_i;
      if (restart) begin
        in_row_q   <= '0;
        in_col_q   <= '0;
        emit_row_q <= '0;
        emit_col_q <= '0;
        pending_q  <= '0;
      end else if (state_q == sgd_pkg::S_CALC) begin
        if (kind_q == sgd_pkg::KIND_PIXEL) begin
          win_q[0] <= win_q[3];
          win_q[1] <= win_q[4];
          win_q[2] <= win_q[5];
          win_q[3] <= up_rd;
          win_q[4] <= mid_rd;
          win_q[5] <= pix_q;
          if ({1'b0, in_col_q} + 1'b1 >= w_eff) begin
            in_col_q <= '0;
            in_row_q <= (in_row_q + 1'b1 >= h_eff) ? '0 : in_row_q + 1'b1;
          end else begin
            in_col_q <= in_col_q + 1'b1;
          end
        end
        if (emit) begin
          if ({1'b0, emit_col_q} + 1'b1 >= w_eff) begin
            emit_col_q <= '0;
            emit_row_q <= (emit_row_q + 1'b1 >= h_eff) ? '0 : emit_row_q + 1'b1;
          end else begin
            emit_col_q <= emit_col_q + 1'b1;
          end
        end
        if (kind_q == sgd_pkg::KIND_PIXEL && !emit) pending_q <= pending_q + 1'b1;
        if (kind_q == sgd_pkg::KIND_DRAIN && emit)  pending_q <= pending_q - 1'b1;
      end
      if (load_out) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == sgd_pkg::S_IDLE && in_valid_i) begin
      kind_q <= in_kind_i;
      pix_q  <= in_pixel_i;
    end
    if (state_q == sgd_pkg::S_CALC) begin
      gx_q        <= (interior && kind_q == sgd_pkg::KIND_PIXEL) ? gx : '0;
      gy_q        <= (interior && kind_q == sgd_pkg::KIND_PIXEL) ? gy : '0;
      res_row_q   <= emit_row_q;
      res_col_q   <= emit_col_q;
      emit_last_q <= last;
    end
    if (state_q == sgd_pkg::S_SQ) begin
      ax2_q  <= ax * ax;
      psum_q <= sum_xy * sum_xy;
      pdif_q <= dif_xy * dif_xy;
      zero_q <= (ax == '0) && (ay == '0);
      ygt_q  <= (ay > ax);
      same_q <= (gx_q > 0) == (gy_q > 0);
    end
    if (load_out) begin
      out_row_o    <= res_row_q;
      out_col_o    <= res_col_q;
      magnitude_o  <= sq_rsp.root;
      direction_o  <= dir;
      frame_last_o <= emit_last_q;
    end
  end

  pending_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= w_eff + 1'b1) else $error("pending count beyond row length");

  calc_after_read_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sgd_pkg::S_CALC |-> $past(state_q) == sgd_pkg::S_READ)
    else $error("window update without line store read");

  root_wait_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sgd_pkg::S_SQ |=> !sq_rsp.done) else $error("square root not started");

  zero_border_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && zero_q |=> magnitude_o == '0 && direction_o == sgd_pkg::DIR_0)
    else $error("nonzero result for zero gradient");

endmodule

// ----- sv/sgd_ram.sv -----
module sgd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/sgd_sqrt.sv -----
module sgd_sqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sgd_pkg::sqrt_req_t req_i,
  output sgd_pkg::sqrt_rsp_t rsp_o
);

  localparam int unsigned W = sgd_pkg::SQ_W + 1;

  logic [W-1:0]              rem_q, rem_d;
  logic [W-1:0]              r_q, r_d;
  logic [W-1:0]              bit_q, bit_d;
  logic [3:0]                cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic [W-1:0]              trial;
  logic [sgd_pkg::ROOT_W-1:0] base;

  // one result bit per cycle
  always_comb begin
    rem_d  = rem_q;
    r_d    = r_q;
    bit_d  = bit_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = r_q + bit_q;
    if (req_i.start) begin
      rem_d  = W'(req_i.value);
      r_d    = '0;
      bit_d  = W'(1) << (2 * (sgd_pkg::ROOT_W - 1));
      cnt_d  = 4'(sgd_pkg::ROOT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        r_d   = (r_q >> 1) + bit_q;
      end else begin
        r_d = r_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q - 4'd1;
      if (cnt_q == 4'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    r_q   <= r_d;
    bit_q <= bit_d;
  end

  // round to nearest from the remainder
  assign base      = r_q[sgd_pkg::ROOT_W-1:0];
  assign rsp_o.done = !busy_q;
  assign rsp_o.root = (rem_q > r_q) ? base + 1'b1 : base;

  sqrt_steps_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q && cnt_q == 4'(sgd_pkg::ROOT_W)) else $error("sqrt start lost");

endmodule
